// File: sv/gapc_pkg.sv
// Shared types, widths and constants of the global average pooling block.
package gapc_pkg;

  localparam int DefaultMaxChannels = 1024;
  localparam int SampleW    = 32;
  localparam int SumW       = 48;
  localparam int ChanIdxW   = 10;
  localparam int ChanCntW   = 11;
  localparam int RowCntW    = 16;
  localparam int ScaleW     = 32;
  localparam int ScaleFracW = 24;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int QueueDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_ROW_COUNT     = 3'd1,
    CFG_SCALE         = 3'd2,
    CFG_OUT_MIN       = 3'd3,
    CFG_OUT_MAX       = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanCntW-1:0]       channel_count;
    logic [RowCntW-1:0]        row_count;
    logic [ScaleW-1:0]         scale;
    logic signed [SampleW-1:0] out_min;
    logic signed [SampleW-1:0] out_max;
  } cfg_t;

  localparam logic [ChanCntW-1:0]       ChanCountRst = 11'd1;
  localparam logic [RowCntW-1:0]        RowCountRst  = 16'd1;
  localparam logic [ScaleW-1:0]         ScaleRst     = 32'h0100_0000;
  localparam logic signed [SampleW-1:0] SatMin       = 32'sh8000_0000;
  localparam logic signed [SampleW-1:0] SatMax       = 32'sh7FFF_FFFF;

endpackage

// File: sv/gapc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gapc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gapc_front.sv
// Front end: takes samples, tracks channel and row position, accumulates per-channel sums.
module gapc_front
  import gapc_pkg::*;
#(
  parameter int MaxChannels = DefaultMaxChannels
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [SampleW-1:0]               sample_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output logic [SumW-1:0]                  push_sum_o,
  output logic [$clog2(MaxChannels)-1:0]   push_idx_o,
  output logic                             push_last_o
);

  localparam int ChanW = $clog2(MaxChannels);
  localparam int PosW  = (ChanW > ChanCntW ? ChanW : ChanCntW) + 1;

  logic [ChanW-1:0]   chan_pos_q, chan_pos_d;
  logic [RowCntW-1:0] row_pos_q, row_pos_d;

  logic               a_valid_q, a_valid_d;
  logic [SampleW-1:0] a_sample_q;
  logic [ChanW-1:0]   a_idx_q;
  logic               a_first_q, a_last_r_q, a_last_c_q, a_hit_q;
  logic [SumW-1:0]    fwd_sum_q;

  logic [PosW-1:0]    chan_p1;
  logic [RowCntW:0]   row_p1;
  logic               last_c, last_r;
  logic               accept, a_adv, a_write;
  logic [SumW-1:0]    rdata, a_base, a_x, a_sum;

  assign chan_p1 = PosW'(chan_pos_q) + PosW'(1);
  assign last_c  = (chan_p1 >= PosW'(cfg_i.channel_count)) || (chan_p1 >= PosW'(MaxChannels));
  assign row_p1  = {1'b0, row_pos_q} + 17'd1;
  assign last_r  = row_p1 >= {1'b0, cfg_i.row_count};

  // Stage A advances unless its word must go to the queue and the queue is full.
  assign a_adv      = !a_last_r_q || push_ready_i;
  assign a_write    = a_valid_q && a_adv;
  assign in_ready_o = !a_valid_q || a_adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    chan_pos_d = chan_pos_q;
    row_pos_d  = row_pos_q;
    if (accept) begin
      if (last_c) begin
        chan_pos_d = '0;
        row_pos_d  = last_r ? '0 : row_p1[RowCntW-1:0];
      end else begin
        chan_pos_d = chan_pos_q + ChanW'(1);
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_pos_q <= '0;
      row_pos_q  <= '0;
      a_valid_q  <= 1'b0;
      a_hit_q    <= 1'b0;
    end else begin
      chan_pos_q <= chan_pos_d;
      row_pos_q  <= row_pos_d;
      a_valid_q  <= a_valid_d;
      if (accept) begin
        // The RAM read misses the write landing on the same edge: forward it.
        a_hit_q <= a_write && (a_idx_q == chan_pos_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_sample_q <= sample_i;
      a_idx_q    <= chan_pos_q;
      a_first_q  <= (row_pos_q == '0);
      a_last_r_q <= last_r;
      a_last_c_q <= last_c;
    end
    if (a_write) begin
      fwd_sum_q <= a_sum;
    end
  end

  gapc_ram #(
    .Width (SumW),
    .Depth (MaxChannels)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (a_write),
    .waddr_i (a_idx_q),
    .wdata_i (a_sum),
    .re_i    (accept),
    .raddr_i (chan_pos_q),
    .rdata_o (rdata)
  );

  assign a_x    = {{(SumW-SampleW){a_sample_q[SampleW-1]}}, a_sample_q};
  assign a_base = a_hit_q ? fwd_sum_q : rdata;
  assign a_sum  = a_first_q ? a_x : a_base + a_x;

  assign push_valid_o = a_valid_q && a_last_r_q;
  assign push_sum_o   = a_sum;
  assign push_idx_o   = a_idx_q;
  assign push_last_o  = a_last_c_q;

endmodule

// File: sv/gapc_queue.sv
// Small register queue between the accumulate front end and the scaling back end.
module gapc_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int PtrW = $clog2(Depth);

  logic [Width-1:0] entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != (PtrW+1)'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (PtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/gapc_back.sv
// Back end: scales each channel total, rounds, saturates, clamps and drives the result.
module gapc_back
  import gapc_pkg::*;
#(
  parameter int MaxChannels = DefaultMaxChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  logic [SumW-1:0]                pop_sum_i,
  input  logic [$clog2(MaxChannels)-1:0] pop_idx_i,
  input  logic                           pop_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [SampleW-1:0]             pooled_o,
  output logic [ChanIdxW-1:0]            chan_index_o,
  output logic                           last_chan_o
);

  localparam int ChanW = $clog2(MaxChannels);
  localparam int HiW   = SumW - ScaleFracW;            // 24
  localparam int PHiW  = HiW + ScaleW + 1;             // 57
  localparam int PLoW  = ScaleFracW + ScaleW;          // 56
  localparam int VW    = PHiW + 1;                     // 58
  localparam int RndW  = PLoW + 1 - ScaleFracW;        // 33

  logic                    en;

  logic                    s1_valid_q;
  logic signed [PHiW-1:0]  s1_phi_q;
  logic [PLoW-1:0]         s1_plo_q;
  logic [ChanW-1:0]        s1_idx_q;
  logic                    s1_last_q;

  logic                    s2_valid_q;
  logic [VW-1:0]           s2_v_q;
  logic [ChanW-1:0]        s2_idx_q;
  logic                    s2_last_q;

  logic                    out_valid_q;
  logic [SampleW-1:0]      pooled_q;
  logic [ChanW-1:0]        idx_q;
  logic                    last_q;

  logic signed [HiW-1:0]   sum_hi;
  logic [ScaleFracW-1:0]   sum_lo;
  logic signed [ScaleW:0]  scale_s;
  logic signed [PHiW-1:0]  phi;
  logic [PLoW-1:0]         plo;
  logic [PLoW:0]           plo_rnd;
  logic [RndW-1:0]         rnd;
  logic [VW-1:0]           v;
  logic                    in_range;
  logic signed [SampleW-1:0] sat, lo_clamped, res;

  // Whole pipeline moves together; hold everything while the output word waits.
  assign en          = !out_valid_q || out_ready_i;
  assign pop_ready_o = en;

  // sum * scale split as sum_hi * scale * 2^24 + sum_lo * scale.
  assign sum_hi  = pop_sum_i[SumW-1:ScaleFracW];
  assign sum_lo  = pop_sum_i[ScaleFracW-1:0];
  assign scale_s = {1'b0, cfg_i.scale};
  assign phi     = sum_hi * scale_s;
  assign plo     = sum_lo * cfg_i.scale;

  // Round half up: add one half at bit 23 before dropping the fraction.
  assign plo_rnd = {1'b0, s1_plo_q} + (PLoW+1)'(1 << (ScaleFracW-1));
  assign rnd     = plo_rnd[PLoW:ScaleFracW];
  assign v       = {s1_phi_q[PHiW-1], s1_phi_q} + {{(VW-RndW){1'b0}}, rnd};

  assign in_range   = (s2_v_q[VW-1:SampleW-1] == {(VW-SampleW+1){s2_v_q[VW-1]}});
  assign sat        = in_range ? $signed(s2_v_q[SampleW-1:0]) :
                      (s2_v_q[VW-1] ? SatMin : SatMax);
  // Lower bound first, so inverted bounds give the upper one.
  assign lo_clamped = (sat < cfg_i.out_min) ? cfg_i.out_min : sat;
  assign res        = (lo_clamped > cfg_i.out_max) ? cfg_i.out_max : lo_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= pop_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_phi_q  <= phi;
      s1_plo_q  <= plo;
      s1_idx_q  <= pop_idx_i;
      s1_last_q <= pop_last_i;
      s2_v_q    <= v;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      pooled_q  <= res;
      idx_q     <= s2_idx_q;
      last_q    <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pooled_o     = pooled_q;
  assign chan_index_o = ChanIdxW'(idx_q);
  assign last_chan_o  = last_q;

endmodule

// File: sv/global_avg_pool_clamp_unit.sv
// Top level of the global average pooling unit with clamped output.
//
// Samples enter on the in_valid_i/in_ready_o channel in row-major order:
// all channels of row 0, then row 1, up to row_count rows. Each channel
// keeps a 48-bit sum in a RAM; row 0 overwrites it, later rows add to it.
// On the last row each sample yields one result word on out_valid_o/
// out_ready_i: the total times scale (Q8.24), rounded half up, saturated
// and clamped to [out_min, out_max], with its channel index and a flag on
// the final channel. Other rows give no result.
// Throughput is one sample per cycle while the queue has room; the sum RAM
// does one read and one write per cycle, with the previous write forwarded
// for back-to-back hits on the same channel. Between a taken sample and its
// result lie one accumulate stage, the queue, a multiply stage and an add
// stage, ahead of the output register. When the receiver stalls, the back
// end holds and the four-word queue absorbs results; the input stalls only
// once the queue is full. Reset clears positions and restores the register
// defaults; the sum RAM is not cleared, since row 0 writes every entry
// before it is read. Configuration is written by the user only while idle,
// through cfg_we_i/cfg_idx_i/cfg_wdata_i; the block leaves this unchecked.
module global_avg_pool_clamp_unit
  import gapc_pkg::*;
#(
  parameter int MaxChannels = DefaultMaxChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SampleW-1:0]  pooled_o,
  output logic [ChanIdxW-1:0] chan_index_o,
  output logic                last_chan_o
);

  localparam int ChanW = $clog2(MaxChannels);
  localparam int QW    = SumW + ChanW + 1;

  cfg_t             cfg_q;
  logic             push_valid, push_ready, push_last;
  logic [SumW-1:0]  push_sum;
  logic [ChanW-1:0] push_idx;
  logic             pop_valid, pop_ready;
  logic [QW-1:0]    pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= ChanCountRst;
      cfg_q.row_count     <= RowCountRst;
      cfg_q.scale         <= ScaleRst;
      cfg_q.out_min       <= SatMin;
      cfg_q.out_max       <= SatMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata_i[ChanCntW-1:0];
        CFG_ROW_COUNT:     cfg_q.row_count     <= cfg_wdata_i[RowCntW-1:0];
        CFG_SCALE:         cfg_q.scale         <= cfg_wdata_i[ScaleW-1:0];
        CFG_OUT_MIN:       cfg_q.out_min       <= $signed(cfg_wdata_i[SampleW-1:0]);
        CFG_OUT_MAX:       cfg_q.out_max       <= $signed(cfg_wdata_i[SampleW-1:0]);
        default: ;
      endcase
    end
  end

  gapc_front #(
    .MaxChannels (MaxChannels)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_sum_o   (push_sum),
    .push_idx_o   (push_idx),
    .push_last_o  (push_last)
  );

  gapc_queue #(
    .Width (QW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_sum, push_idx, push_last}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  gapc_back #(
    .MaxChannels (MaxChannels)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_sum_i    (pop_data[QW-1:ChanW+1]),
    .pop_idx_i    (pop_data[ChanW:1]),
    .pop_last_i   (pop_data[0]),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pooled_o     (pooled_o),
    .chan_index_o (chan_index_o),
    .last_chan_o  (last_chan_o)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench of global_avg_pool_clamp_unit with a cycle-free predictor.
module tb_top;
  import gapc_pkg::*;

  typedef struct packed {
    logic signed [SampleW-1:0] pooled;
    logic [ChanIdxW-1:0]       chan_index;
    logic                      last_chan;
  } pooled_word_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_BUSY,
    RX_CHOKED
  } rx_mode_e;

  localparam int MaxChan = DefaultMaxChannels;
  localparam logic signed [81:0] WideHi = 82'sd2147483647;
  localparam logic signed [81:0] WideLo = -82'sd2147483648;
  localparam logic signed [81:0] HalfLsb = 82'sd8388608;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  sample_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SampleW-1:0]  pooled_o;
  logic [ChanIdxW-1:0] chan_index_o;
  logic                last_chan_o;

  global_avg_pool_clamp_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pooled_o     (pooled_o),
    .chan_index_o (chan_index_o),
    .last_chan_o  (last_chan_o)
  );

  // predictor copy of the registers and the accumulator state
  logic [ChanCntW-1:0]       chan_count_q = ChanCountRst;
  logic [RowCntW-1:0]        row_count_q  = RowCountRst;
  logic [ScaleW-1:0]         scale_q      = ScaleRst;
  logic signed [SampleW-1:0] lo_bound_q   = SatMin;
  logic signed [SampleW-1:0] hi_bound_q   = SatMax;
  logic signed [SumW-1:0]    chan_total [MaxChan];
  int                        chan_at = 0;
  int                        row_at  = 0;

  logic [SampleW-1:0] sample_backlog [$];
  pooled_word_t       pooled_expect [$];
  int                 mismatches = 0;

  bit       word_taken = 1'b0;
  int       gap_left = 0;
  int       burst_left = 1;
  int       rx_hold = 0;
  int       rx_phase_left = 0;
  rx_mode_e rx_mode = RX_FREE;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #30000000;
    $display("status: fail");
    $finish;
  end

  function automatic int eff_channels();
    if (chan_count_q == 0) return 1;
    if (chan_count_q > MaxChan) return MaxChan;
    return int'(chan_count_q);
  endfunction

  function automatic int eff_rows();
    return (row_count_q == 0) ? 1 : int'(row_count_q);
  endfunction

  // total * scale / 2^24, rounded half up, saturated, then min bound, then max bound
  function automatic logic signed [SampleW-1:0] scale_clamp(logic signed [SumW-1:0] total);
    logic signed [81:0]        prod;
    logic signed [SampleW-1:0] v;
    prod = $signed({{34{total[SumW-1]}}, total}) * $signed({50'd0, scale_q});
    prod = (prod + HalfLsb) >>> ScaleFracW;
    if (prod > WideHi) v = SatMax;
    else if (prod < WideLo) v = SatMin;
    else v = prod[SampleW-1:0];
    if (v < lo_bound_q) v = lo_bound_q;
    if (v > hi_bound_q) v = hi_bound_q;
    return v;
  endfunction

  task automatic accumulate_word(input logic [SampleW-1:0] smp);
    int                     nch;
    int                     idx;
    bit                     lc;
    bit                     lr;
    logic signed [SumW-1:0] total;
    pooled_word_t           w;
    nch = eff_channels();
    idx = chan_at % MaxChan;
    lc = (chan_at + 1 >= nch);
    lr = (row_at + 1 >= eff_rows());
    if (row_at == 0) total = $signed({{16{smp[31]}}, smp});
    else total = chan_total[idx] + $signed({{16{smp[31]}}, smp});
    chan_total[idx] = total;
    if (lr) begin
      w.pooled = scale_clamp(total);
      w.chan_index = idx[ChanIdxW-1:0];
      w.last_chan = lc;
      pooled_expect.push_back(w);
    end
    if (lc) begin
      chan_at = 0;
      row_at = lr ? 0 : row_at + 1;
    end else begin
      chan_at = chan_at + 1;
    end
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= d;
    case (r)
      CFG_CHANNEL_COUNT: chan_count_q = d[ChanCntW-1:0];
      CFG_ROW_COUNT:     row_count_q = d[RowCntW-1:0];
      CFG_SCALE:         scale_q = d;
      CFG_OUT_MIN:       lo_bound_q = d;
      CFG_OUT_MAX:       hi_bound_q = d;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hold the sender until every word is taken and every result is back,
  // then let words that give no result leave the pipeline
  task automatic settle();
    while (sample_backlog.size() != 0 || in_valid_i || pooled_expect.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SatMax;
      1: return SatMin;
      2: return SampleW'($signed($urandom_range(0, 511)) - 256);
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of words with random gaps in between
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (sample_backlog.size() > 0) begin
          in_valid_i <= 1'b1;
          sample_i <= sample_backlog.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      word_taken = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      accumulate_word(sample_i);
      word_taken = 1'b1;
    end
  end

  // receiver: long hold-off on request, otherwise stall pattern by mode
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        if (rx_phase_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          rx_phase_left = $urandom_range(16, 128);
        end
        rx_phase_left--;
        case (rx_mode)
          RX_FREE: out_ready_i <= 1'b1;
          RX_BUSY: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    pooled_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pooled_expect.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result at %0t: pooled %h chan %0d last %0b",
                   $time, pooled_o, chan_index_o, last_chan_o);
        mismatches++;
      end else begin
        w = pooled_expect.pop_front();
        if (pooled_o !== w.pooled || chan_index_o !== w.chan_index ||
            last_chan_o !== w.last_chan) begin
          if (mismatches < 10)
            $display("mismatch at %0t: pooled %h/%h chan %0d/%0d last %0b/%0b (exp/got)",
                     $time, w.pooled, pooled_o, w.chan_index, chan_index_o,
                     w.last_chan, last_chan_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          random_words;
    int          n;
    int          frame;
    logic [31:0] d;
    logic [31:0] a;
    logic [31:0] b;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: unity scale passes samples through
    sample_backlog.push_back(SatMax);
    sample_backlog.push_back(SatMin);
    sample_backlog.push_back(32'h0);
    sample_backlog.push_back(32'h1);
    sample_backlog.push_back(32'hFFFF_FFFF);
    settle();

    // zero counts act as one; half-way products round toward +inf
    write_reg(CFG_CHANNEL_COUNT, 32'h0);
    write_reg(CFG_ROW_COUNT, 32'h0);
    write_reg(CFG_SCALE, 32'h0080_0000);
    write_reg(CFG_OUT_MIN, SatMin);
    write_reg(CFG_OUT_MAX, SatMax);
    sample_backlog.push_back(32'h1);
    sample_backlog.push_back(32'hFFFF_FFFF);
    sample_backlog.push_back(32'h3);
    sample_backlog.push_back(32'hFFFF_FFFD);
    settle();

    // huge scale: saturation, then clamp to [-327680, 458752]
    write_reg(CFG_CHANNEL_COUNT, 32'd3);
    write_reg(CFG_ROW_COUNT, 32'd2);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_OUT_MIN, 32'hFFFB_0000);
    write_reg(CFG_OUT_MAX, 32'h0007_0000);
    sample_backlog.push_back(SatMax);
    sample_backlog.push_back(SatMin);
    sample_backlog.push_back(32'h1);
    sample_backlog.push_back(SatMax);
    sample_backlog.push_back(SatMin);
    sample_backlog.push_back(32'hFFFF_FFFF);
    settle();

    // inverted bounds give the upper bound
    write_reg(CFG_CHANNEL_COUNT, 32'd2);
    write_reg(CFG_ROW_COUNT, 32'd1);
    write_reg(CFG_OUT_MIN, 32'd100);
    write_reg(CFG_OUT_MAX, 32'hFFFF_FF9C);
    sample_backlog.push_back(SatMax);
    sample_backlog.push_back(SatMin);
    settle();

    // shrink both counts in the middle of a frame; the position wraps
    write_reg(CFG_CHANNEL_COUNT, 32'd4);
    write_reg(CFG_ROW_COUNT, 32'd3);
    write_reg(CFG_SCALE, 32'h0055_5555);
    write_reg(CFG_OUT_MIN, SatMin);
    write_reg(CFG_OUT_MAX, SatMax);
    for (int i = 0; i < 6; i++) sample_backlog.push_back(random_sample());
    settle();
    write_reg(CFG_CHANNEL_COUNT, 32'd2);
    write_reg(CFG_ROW_COUNT, 32'd2);
    for (int i = 0; i < 5; i++) sample_backlog.push_back(random_sample());
    settle();

    // widest row, cut short; every word a result, receiver held off long
    // enough to fill up
    write_reg(CFG_CHANNEL_COUNT, 32'd2047);
    write_reg(CFG_ROW_COUNT, 32'd1);
    write_reg(CFG_SCALE, $urandom);
    rx_hold = 400;
    for (int i = 0; i < 64; i++) sample_backlog.push_back(random_sample());
    settle();

    // long column on a single channel; the first word closes the short row
    write_reg(CFG_CHANNEL_COUNT, 32'd1);
    write_reg(CFG_ROW_COUNT, 32'd48);
    write_reg(CFG_SCALE, ($urandom_range(0, 1) == 0) ? 32'h0000_0100 : 32'hFFFF_FFFF);
    for (int i = 0; i < 48; i++) sample_backlog.push_back(random_sample());
    settle();

    random_words = 0;
    while (random_words < 360) begin
      d = $urandom;
      case ($urandom_range(0, 9))
        0:       d[ChanCntW-1:0] = '0;
        1, 2:    d[ChanCntW-1:0] = ChanCntW'($urandom_range(9, 40));
        default: d[ChanCntW-1:0] = ChanCntW'($urandom_range(1, 8));
      endcase
      write_reg(CFG_CHANNEL_COUNT, d);
      d = $urandom;
      d[RowCntW-1:0] = RowCntW'($urandom_range(0, 4));
      write_reg(CFG_ROW_COUNT, d);
      case ($urandom_range(0, 4))
        0: write_reg(CFG_SCALE, 32'h0100_0000 / eff_rows());
        1: write_reg(CFG_SCALE, $urandom);
        2: write_reg(CFG_SCALE, 32'h0);
        3: write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        default: write_reg(CFG_SCALE, $urandom_range(0, 32'h0200_0000));
      endcase
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 3))
        0, 1: begin
          write_reg(CFG_OUT_MIN, SatMin);
          write_reg(CFG_OUT_MAX, SatMax);
        end
        2: begin
          write_reg(CFG_OUT_MIN, ($signed(a) < $signed(b)) ? a : b);
          write_reg(CFG_OUT_MAX, ($signed(a) < $signed(b)) ? b : a);
        end
        default: begin
          write_reg(CFG_OUT_MIN, a);
          write_reg(CFG_OUT_MAX, b);
        end
      endcase
      frame = eff_channels() * eff_rows();
      n = $urandom_range(1, 3) * frame;
      // trim whole frames near the end of the run
      while (n > frame && random_words + n > 380) n -= frame;
      for (int i = 0; i < n; i++) sample_backlog.push_back(random_sample());
      random_words += n;
      settle();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
